// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/mscms_pkg.sv
// Package: types and constants for the multi-switch count-min sketch.
package mscms_pkg;
    localparam logic [39:0] EST_CAP = 40'd999999999999;
    localparam logic [63:0] CTR_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [3:0]  KEY_MAX = 4'd13;
    localparam logic        OP_ADD = 1'b0;
    localparam logic        OP_QUERY = 1'b1;
    localparam logic [1:0]  CFG_SEED0 = 2'd0;
    localparam logic [1:0]  CFG_SEED3 = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  switch_id;
        logic [63:0] key_lo;
        logic [39:0] key_hi;
        logic [3:0]  key_bytes;
        logic [15:0] amount;
    } req_t;

    typedef struct packed {
        logic [39:0] estimate;
    } rsp_t;

    // Handshake between the top level and the hash core.
    typedef struct packed {
        logic start;
        logic done;
    } hash_ctl_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
                6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
                6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
                6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
                6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
                6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
                6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
                6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
                6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
                6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
                6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
                default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
                4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
                4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction
endpackage

// File: rtl/mscms_if.sv
// Valid/ready channel interfaces for requests and responses.
interface mscms_req_if;
    import mscms_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mscms_rsp_if;
    import mscms_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/mscms_md5.sv
// Iterative MD5 core: one round per cycle, returns the sum of the digest words.
module mscms_md5
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           key_lo,
    input  logic [39:0]           key_hi,
    input  logic [3:0]            key_bytes,
    output mscms_pkg::hash_ctl_t  ctl,
    output logic [31:0]           hsum
);
    import mscms_pkg::*;

    logic [511:0] blk_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [5:0]   rnd_reg;
    logic         busy_reg, fin_reg, done_reg;
    logic [31:0]  hsum_reg;

    logic [3:0]   len;
    logic [511:0] blk_next;
    logic [31:0]  f, m, sum, rot;
    logic [3:0]   g;
    logic [103:0] key;

    // Build the padded block from the clamped key.
    always_comb
    begin
        len = (key_bytes > KEY_MAX) ? KEY_MAX : key_bytes;
        key = {key_hi, key_lo};
        blk_next = '0;
        for (int i = 0; i < 13; i++)
        begin
            if (i < int'(len))
                blk_next[i*8 +: 8] = key[i*8 +: 8];
        end
        blk_next[{len, 3'b000} +: 8] = 8'h80;
        blk_next[448 +: 7] = {len, 3'b000};
    end

    // One MD5 round.
    always_comb
    begin
        unique case (rnd_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = rnd_reg[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(5 * rnd_reg[3:0] + 1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(3 * rnd_reg[3:0] + 5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(7 * rnd_reg[3:0]);
            end
        endcase
        m = blk_reg[{g, 5'b00000} +: 32];
        sum = f + a_reg + md5_k(rnd_reg) + m;
        rot = (sum << md5_s(rnd_reg)) | (sum >> (6'd32 - {1'b0, md5_s(rnd_reg)}));
    end

    // Sequence the 64 rounds, then fold the digest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                blk_reg  <= blk_next;
                a_reg    <= 32'h67452301;
                b_reg    <= 32'hefcdab89;
                c_reg    <= 32'h98badcfe;
                d_reg    <= 32'h10325476;
                rnd_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_reg + rot;
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                hsum_reg <= (a_reg + 32'h67452301) + (b_reg + 32'hefcdab89)
                          + (c_reg + 32'h98badcfe) + (d_reg + 32'h10325476);
            end
        end
    end

    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign hsum      = hsum_reg;
endmodule

// File: rtl/multi_switch_count_min_sketch_top.sv
// Top level of the multi-switch count-min sketch.
// Transactions run one at a time. After acceptance the iterative hash core runs its 64 MD5
// rounds. Each row then reduces its seeded hash modulo ROW_WIDTH by reciprocal
// multiplication in S_COL (multiply) and S_MOD (subtract). Each visited counter passes
// through S_RD, S_WAIT and S_UPD (read, wait, update) on the single counter memory port,
// and a query skips an unseen switch in S_RD. The input opens again the cycle after the
// result is taken. After reset a clearing pass walks all SWITCHES*ROWS*ROW_WIDTH entries
// of the counter memory, one entry per cycle, before the first transaction is accepted.
module multi_switch_count_min_sketch_top
#(
    parameter int ROW_WIDTH = 1024,
    parameter int ROWS      = 4,
    parameter int SWITCHES  = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    mscms_req_if.sink         req,
    mscms_rsp_if.source       rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import mscms_pkg::*;

    localparam int DEPTH = SWITCHES * ROWS * ROW_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(ROW_WIDTH);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW    = (SWITCHES > 1) ? $clog2(SWITCHES) : 1;
    // Reciprocal of ROW_WIDTH, exact for every 32-bit dividend.
    localparam logic [63:0] RECIP = ((64'd1 << (32 + CW)) + 64'(ROW_WIDTH) - 64'd1)
                                  / 64'(ROW_WIDTH);

    typedef enum logic [3:0] {S_CLEAR, S_IDLE, S_HASH, S_COL, S_MOD, S_RD, S_WAIT, S_UPD,
                              S_OUT} state_t;

    logic [63:0]  mem [DEPTH];
    state_t       state_reg;
    req_t         req_reg;
    logic [31:0]  seed_reg [4];
    logic [SWITCHES-1:0] seen_reg;
    logic [AW:0]  clr_reg;
    logic [31:0]  hsum_reg;
    logic [RW-1:0] row_reg;
    logic [SW-1:0] sw_reg;
    logic [63:0]  rd_reg;
    logic [39:0]  best_reg;
    logic         rsp_valid_reg;
    logic [39:0]  rsp_est_reg;
    logic         start_reg;
    logic [64:0]  prod_reg;
    logic [CW-1:0] col_reg [ROWS];

    hash_ctl_t    hctl;
    logic [31:0]  hsum;
    logic [31:0]  hx;
    logic [64:0]  prod_next;
    logic [31:0]  quot;
    logic [31:0]  rem;
    logic [AW-1:0] addr;
    logic [SW-1:0] sw_sel;
    logic [64:0]  add_sum;
    logic [63:0]  wr_val;
    logic         last_row;
    logic         last_sw;

    mscms_md5 u_md5
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .key_lo    (req_reg.key_lo),
        .key_hi    (req_reg.key_hi),
        .key_bytes (req_reg.key_bytes),
        .ctl       (hctl),
        .hsum      (hsum)
    );

    // Reduce the seeded row hash and form the counter address for the current switch and row.
    always_comb
    begin
        hx        = hsum_reg ^ seed_reg[2'(row_reg)];
        prod_next = 65'(hx) * 65'(RECIP[32:0]);
        quot      = 32'(prod_reg >> (32 + CW));
        rem       = hx - quot * 32'(ROW_WIDTH);
        sw_sel = (req_reg.opcode == OP_ADD) ? SW'(req_reg.switch_id) : sw_reg;
        addr   = AW'((32'(sw_sel) * 32'(ROWS) + 32'(row_reg)) * 32'(ROW_WIDTH)
               + 32'(col_reg[row_reg]));
        add_sum = {1'b0, rd_reg} + 65'(req_reg.amount);
        wr_val  = (add_sum > 65'(CTR_MAX)) ? CTR_MAX : add_sum[63:0];
        last_row = (32'(row_reg) == ROWS - 1);
        last_sw  = (32'(sw_reg) == SWITCHES - 1);
    end

    // Write seeds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                seed_reg[i] <= '0;
        end
        else if (cfg_we && cfg_index >= CFG_SEED0 && cfg_index <= CFG_SEED3)
            seed_reg[cfg_index] <= cfg_data;
    end

    // Counter memory: one port, read data registered.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            mem[clr_reg[AW-1:0]] <= '0;
        else if (state_reg == S_UPD && req_reg.opcode == OP_ADD)
            mem[addr] <= wr_val;
        rd_reg <= mem[addr];
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            seen_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            row_reg       <= '0;
            sw_reg        <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req.valid && !rsp_valid_reg)
                    begin
                        req_reg   <= req.data;
                        start_reg <= 1'b1;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hctl.done)
                    begin
                        hsum_reg <= hsum;
                        row_reg  <= '0;
                        sw_reg   <= '0;
                        best_reg <= EST_CAP;
                        if (req_reg.opcode == OP_ADD)
                        begin
                            if (32'(req_reg.switch_id) < SWITCHES)
                            begin
                                seen_reg[SW'(req_reg.switch_id)] <= 1'b1;
                                state_reg <= S_COL;
                            end
                            else
                                state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_COL;
                    end
                end
                // Multiply the row hash by the reciprocal.
                S_COL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_MOD;
                end
                // Subtract the quotient multiple and keep the column.
                S_MOD:
                begin
                    col_reg[row_reg] <= rem[CW-1:0];
                    if (last_row)
                    begin
                        row_reg   <= '0;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= S_COL;
                    end
                end
                S_RD:
                begin
                    if (req_reg.opcode == OP_QUERY && !seen_reg[sw_reg])
                    begin
                        row_reg <= '0;
                        if (last_sw)
                            state_reg <= S_OUT;
                        else
                            sw_reg <= sw_reg + 1'b1;
                    end
                    else
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                    state_reg <= S_UPD;
                S_UPD:
                begin
                    if (req_reg.opcode == OP_QUERY && rd_reg < 64'(best_reg))
                        best_reg <= rd_reg[39:0];
                    state_reg <= S_RD;
                    if (last_row)
                    begin
                        row_reg <= '0;
                        if (req_reg.opcode == OP_ADD || last_sw)
                            state_reg <= S_OUT;
                        else
                            sw_reg <= sw_reg + 1'b1;
                    end
                    else
                        row_reg <= row_reg + 1'b1;
                end
                S_OUT:
                begin
                    rsp_valid_reg <= 1'b1;
                    rsp_est_reg   <= (req_reg.opcode == OP_ADD) ? '0 : best_reg;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready         = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.data.estimate = rsp_est_reg;
endmodule

// File: rtl/mscms_checker.sv
// Port-level checker for the count-min sketch top level, with its bind.
`include "assert_macros.svh"
module mscms_checker
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [39:0] rsp_estimate
);
    // Hold a stalled result.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    // Never take a request while a result waits.
    `ASSERT_IMPL(a_no_overlap, clk, rst_n, rsp_valid, !req_ready)
    // Estimate never exceeds the cap.
    `ASSERT_IMPL(a_cap, clk, rst_n, rsp_valid, rsp_estimate <= 40'd999999999999)
    // Busy right after accepting.
    `ASSERT_NEXT(a_busy, clk, rst_n, req_valid && req_ready, !req_ready)
endmodule

bind multi_switch_count_min_sketch_top mscms_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_estimate (rsp.data.estimate)
);
